@@ hdl/grc_pkg.sv @@
// ----------------------------------------------------------------------------
// grc_pkg
// Shared types and constants of the grid ray caster column unit.
// ----------------------------------------------------------------------------
package grc_pkg;

  localparam int unsigned CFG_W  = 16;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned COL_W  = 11;
  localparam int unsigned CODE_W = 8;
  localparam int unsigned DIST_W = 16;
  localparam int unsigned ROW_W  = 11;
  localparam int unsigned SCR_W  = 12;
  localparam int unsigned DIV_W  = 32;  // dividend and quotient width
  localparam int unsigned DVS_W  = 17;  // divisor and remainder width
  localparam int unsigned TW     = 20;  // side distance numerators, Q.10
  localparam int unsigned RW     = 19;  // signed ray components, Q.14
  localparam int unsigned ABS_W  = 17;  // ray component magnitudes
  localparam int unsigned FRAC_W = 10;

  localparam logic [CODE_W-1:0] EMPTY_CODE = 8'd48;
  localparam logic [SCR_W-1:0]  MAX_HEIGHT = 12'd2048;

  localparam logic [CFG_W-1:0] RST_POS_X   = 16'd10240;
  localparam logic [CFG_W-1:0] RST_POS_Y   = 16'd10240;
  localparam logic [CFG_W-1:0] RST_DIR_X   = 16'hC000;
  localparam logic [CFG_W-1:0] RST_DIR_Y   = 16'd0;
  localparam logic [CFG_W-1:0] RST_PLANE_X = 16'd0;
  localparam logic [CFG_W-1:0] RST_PLANE_Y = 16'd10813;
  localparam logic [SCR_W-1:0] RST_WIDTH   = 12'd640;
  localparam logic [SCR_W-1:0] RST_HEIGHT  = 12'd480;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_CAST  = 1'b1
  } grc_op_e;

  typedef enum logic [IDX_W-1:0] {
    REG_POS_X   = 3'd0,
    REG_POS_Y   = 3'd1,
    REG_DIR_X   = 3'd2,
    REG_DIR_Y   = 3'd3,
    REG_PLANE_X = 3'd4,
    REG_PLANE_Y = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } grc_reg_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic cam_start;
    logic cam_take;
    logic ray_load;
    logic walk_init;
    logic step;
    logic dist_start;
    logic dist_take;
    logic lh_start;
    logic push;
    logic push_esc;
  } grc_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cast_go;
    logic div_busy;
    logic escape;
    logic leave;
    logic hit;
    logic steps_done;
    logic out_free;
  } grc_sts_t;

endpackage

@@ hdl/grid_ray_caster_column_unit.sv @@
// ----------------------------------------------------------------------------
// grid_ray_caster_column_unit
// Column ray caster over a square cell map, walked cell by cell (DDA).
// ----------------------------------------------------------------------------
// Usage. The input channel carries two kinds of request. A write request
// (command 0) stores one cell code in the map in the cycle it is accepted and
// produces no result. A cast request (command 1) names a screen column; it
// produces one result on the output channel unless the column is not below
// screen_width, in which case it is dropped. Configuration is written through
// the cfg channel, which is always ready; the user must write it only while
// no cast is in flight, as the block itself does not enforce this.
// Sequencing. One cast is worked on at a time. Its time is set by the shared
// one-bit-per-cycle divider (a camera division for every cast, plus distance
// and line height divisions for a hit) and by the walk, which for each cell
// takes a step and then checks the registered map read. The next request is
// accepted in the cycle after the result loads.
// Stalls. A finished result sits in the output register; a new request is
// accepted while it waits. A cast that completes while the register is still
// held by a stalled receiver waits in place until the register frees.
// Reset. Reset returns the sequencer to idle, empties the output register
// and loads the default camera. The map is not cleared: every cell must be
// written before a cast reads it.
// ----------------------------------------------------------------------------
module grid_ray_caster_column_unit #(
  parameter int unsigned MAP_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [grc_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [grc_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         command_i,
  input  logic [grc_pkg::COL_W-1:0]    column_i,
  input  logic [5:0]                   cell_x_i,
  input  logic [5:0]                   cell_y_i,
  input  logic [grc_pkg::CODE_W-1:0]   cell_code_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [grc_pkg::COL_W-1:0]    out_column_o,
  output logic                         wall_side_o,
  output logic [grc_pkg::CODE_W-1:0]   hit_code_o,
  output logic [grc_pkg::DIST_W-1:0]   wall_distance_o,
  output logic [grc_pkg::ROW_W-1:0]    draw_start_o,
  output logic [grc_pkg::ROW_W-1:0]    draw_end_o,
  output logic                         escaped_o
);

  grc_pkg::grc_ctl_t ctl;
  grc_pkg::grc_sts_t sts;

  // Registers are plain flops, so a write never has to wait.
  assign cfg_ready_o = 1'b1;

  grc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  grc_datapath #(
    .MAP_SIZE (MAP_SIZE)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .command_i       (command_i),
    .column_i        (column_i),
    .cell_x_i        (cell_x_i),
    .cell_y_i        (cell_y_i),
    .cell_code_i     (cell_code_i),
    .out_stall_i     (out_stall_i),
    .ctl_i           (ctl),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_column_o    (out_column_o),
    .wall_side_o     (wall_side_o),
    .hit_code_o      (hit_code_o),
    .wall_distance_o (wall_distance_o),
    .draw_start_o    (draw_start_o),
    .draw_end_o      (draw_end_o),
    .escaped_o       (escaped_o)
  );

endmodule

@@ hdl/grc_div.sv @@
// ----------------------------------------------------------------------------
// grc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module grc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [grc_pkg::DIV_W-1:0]   dividend_i,
  input  logic [grc_pkg::DVS_W-1:0]   divisor_i,
  output logic                        busy_o,
  output logic [grc_pkg::DIV_W-1:0]   quot_o,
  output logic [grc_pkg::DVS_W-1:0]   rem_o
);

  localparam int unsigned CNT_W = $clog2(grc_pkg::DIV_W);

  logic                        busy_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [grc_pkg::DIV_W-1:0]   quot_q, quot_d;
  logic [grc_pkg::DVS_W-1:0]   rem_q, rem_d, dvs_q;
  logic [grc_pkg::DVS_W:0]     shifted;
  logic [grc_pkg::DVS_W+1:0]   diff;
  logic                        ge;

  always_comb begin
    shifted = {rem_q, quot_q[grc_pkg::DIV_W-1]};
    diff    = {1'b0, shifted} - {2'b00, dvs_q};
    ge      = ~diff[grc_pkg::DVS_W+1];
    rem_d   = ge ? diff[grc_pkg::DVS_W-1:0] : shifted[grc_pkg::DVS_W-1:0];
    quot_d  = {quot_q[grc_pkg::DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(grc_pkg::DIV_W - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quot_q <= dividend_i;
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ hdl/grc_datapath.sv @@
// ----------------------------------------------------------------------------
// grc_datapath
// Configuration registers, map memory, ray setup, DDA walk and result register.
// ----------------------------------------------------------------------------
module grc_datapath #(
  parameter int unsigned MAP_SIZE = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [grc_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [grc_pkg::CFG_W-1:0]    cfg_data_i,
  input  logic                         command_i,
  input  logic [grc_pkg::COL_W-1:0]    column_i,
  input  logic [5:0]                   cell_x_i,
  input  logic [5:0]                   cell_y_i,
  input  logic [grc_pkg::CODE_W-1:0]   cell_code_i,
  input  logic                         out_stall_i,
  input  grc_pkg::grc_ctl_t            ctl_i,
  output grc_pkg::grc_sts_t            sts_o,
  output logic                         out_valid_o,
  output logic [grc_pkg::COL_W-1:0]    out_column_o,
  output logic                         wall_side_o,
  output logic [grc_pkg::CODE_W-1:0]   hit_code_o,
  output logic [grc_pkg::DIST_W-1:0]   wall_distance_o,
  output logic [grc_pkg::ROW_W-1:0]    draw_start_o,
  output logic [grc_pkg::ROW_W-1:0]    draw_end_o,
  output logic                         escaped_o
);

  localparam int unsigned AW       = $clog2(MAP_SIZE);
  localparam int unsigned CW       = AW + 2;
  localparam int unsigned DEPTH    = 1 << (2 * AW);
  localparam int unsigned STEP_MAX = 2 * MAP_SIZE + 4;
  localparam int unsigned SCW      = $clog2(STEP_MAX + 1);

  localparam int unsigned TW    = grc_pkg::TW;
  localparam int unsigned RW    = grc_pkg::RW;
  localparam int unsigned ABS_W = grc_pkg::ABS_W;
  localparam int unsigned DIV_W = grc_pkg::DIV_W;
  localparam int unsigned DVS_W = grc_pkg::DVS_W;

  // Configuration registers.
  logic [grc_pkg::CFG_W-1:0] pos_x_q, pos_y_q, dir_x_q, dir_y_q, plane_x_q, plane_y_q;
  logic [grc_pkg::SCR_W-1:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q   <= grc_pkg::RST_POS_X;
      pos_y_q   <= grc_pkg::RST_POS_Y;
      dir_x_q   <= grc_pkg::RST_DIR_X;
      dir_y_q   <= grc_pkg::RST_DIR_Y;
      plane_x_q <= grc_pkg::RST_PLANE_X;
      plane_y_q <= grc_pkg::RST_PLANE_Y;
      width_q   <= grc_pkg::RST_WIDTH;
      height_q  <= grc_pkg::RST_HEIGHT;
    end else if (cfg_valid_i) begin
      case (grc_pkg::grc_reg_e'(cfg_index_i))
        grc_pkg::REG_POS_X:   pos_x_q   <= cfg_data_i;
        grc_pkg::REG_POS_Y:   pos_y_q   <= cfg_data_i;
        grc_pkg::REG_DIR_X:   dir_x_q   <= cfg_data_i;
        grc_pkg::REG_DIR_Y:   dir_y_q   <= cfg_data_i;
        grc_pkg::REG_PLANE_X: plane_x_q <= cfg_data_i;
        grc_pkg::REG_PLANE_Y: plane_y_q <= cfg_data_i;
        grc_pkg::REG_WIDTH:   width_q   <= cfg_data_i[grc_pkg::SCR_W-1:0];
        grc_pkg::REG_HEIGHT:  height_q  <= cfg_data_i[grc_pkg::SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider shared by camera, distance and line height.
  logic               div_start, div_busy;
  logic [DIV_W-1:0]   div_dividend, div_quot;
  logic [DVS_W-1:0]   div_divisor, div_rem;

  logic [grc_pkg::COL_W-1:0]   col_q;
  logic signed [12:0]          cam_num;
  logic                        cam_neg;
  logic [12:0]                 cam_abs;
  logic [grc_pkg::DIST_W-1:0]  dist_q;
  logic [grc_pkg::SCR_W-1:0]   h_eff;
  logic [TW-1:0]               perp_q;
  logic                        side_q;
  logic [ABS_W-1:0]            adx_q, ady_q;

  always_comb begin
    cam_num = $signed({1'b0, col_q, 1'b0}) - $signed({1'b0, width_q});
    cam_neg = cam_num[12];
    cam_abs = cam_neg ? 13'(-cam_num) : 13'(cam_num);
    h_eff   = (height_q > grc_pkg::MAX_HEIGHT) ? grc_pkg::MAX_HEIGHT : height_q;
  end

  always_comb begin
    div_start = ctl_i.cam_start | ctl_i.dist_start | ctl_i.lh_start;
    if (ctl_i.dist_start) begin
      div_dividend = {perp_q, 12'd0};
      div_divisor  = side_q ? ady_q : adx_q;
    end else if (ctl_i.lh_start) begin
      div_dividend = DIV_W'({h_eff, 8'd0});
      div_divisor  = DVS_W'(dist_q);
    end else begin
      div_dividend = DIV_W'({cam_abs, 14'd0});
      div_divisor  = DVS_W'(width_q);
    end
  end

  grc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  // Camera coordinate and ray direction.
  logic signed [15:0] cam_q;
  logic [15:0]        cam_mag;
  logic signed [31:0] prod_x, prod_y;
  logic signed [RW-1:0] rdx_q, rdy_q, rdx_d, rdy_d;

  always_comb begin
    cam_mag = div_quot[15:0] + 16'(cam_neg && (div_rem != '0));
    prod_x  = $signed(plane_x_q) * cam_q;
    prod_y  = $signed(plane_y_q) * cam_q;
    rdx_d   = RW'($signed(dir_x_q)) + RW'(prod_x >>> 14);
    rdy_d   = RW'($signed(dir_y_q)) + RW'(prod_y >>> 14);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      col_q <= column_i;
    end
    if (ctl_i.cam_take) begin
      cam_q <= cam_neg ? $signed(-cam_mag) : $signed(cam_mag);
    end
    if (ctl_i.ray_load) begin
      rdx_q <= rdx_d;
      rdy_q <= rdy_d;
    end
  end

  // DDA walk.
  localparam int unsigned FRAC_LAST = grc_pkg::FRAC_W - 1;

  logic [TW-1:0]          tx_q, ty_q;
  logic signed [CW-1:0]   mx_q, my_q, mx_n, my_n, step_x, step_y;
  logic                   negx_q, negy_q;
  logic [SCW-1:0]         cnt_q;
  logic [TW+ABS_W-1:0]    cross_a, cross_b;
  logic                   take_x, leave;
  logic [ABS_W-1:0]       adx_d, ady_d;

  always_comb begin
    adx_d   = rdx_q[RW-1] ? ABS_W'(-rdx_q) : ABS_W'(rdx_q);
    ady_d   = rdy_q[RW-1] ? ABS_W'(-rdy_q) : ABS_W'(rdy_q);
    cross_a = (TW+ABS_W)'(tx_q) * (TW+ABS_W)'(ady_q);
    cross_b = (TW+ABS_W)'(ty_q) * (TW+ABS_W)'(adx_q);
    take_x  = cross_a < cross_b;
    step_x  = negx_q ? '1 : CW'(1);
    step_y  = negy_q ? '1 : CW'(1);
    mx_n    = take_x ? mx_q + step_x : mx_q;
    my_n    = take_x ? my_q : my_q + step_y;
    leave   = mx_n[CW-1] || my_n[CW-1] ||
              ($unsigned(mx_n) >= CW'(MAP_SIZE)) || ($unsigned(my_n) >= CW'(MAP_SIZE));
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.walk_init) begin
      adx_q  <= adx_d;
      ady_q  <= ady_d;
      negx_q <= rdx_q[RW-1];
      negy_q <= rdy_q[RW-1];
      tx_q   <= rdx_q[RW-1] ? TW'(pos_x_q[FRAC_LAST:0])
                            : TW'(11'd1024 - {1'b0, pos_x_q[FRAC_LAST:0]});
      ty_q   <= rdy_q[RW-1] ? TW'(pos_y_q[FRAC_LAST:0])
                            : TW'(11'd1024 - {1'b0, pos_y_q[FRAC_LAST:0]});
      mx_q   <= CW'(pos_x_q[15:10]);
      my_q   <= CW'(pos_y_q[15:10]);
    end else if (ctl_i.step) begin
      mx_q <= mx_n;
      my_q <= my_n;
      if (take_x) begin
        perp_q <= tx_q;
        tx_q   <= tx_q + TW'(1024);
        side_q <= 1'b0;
      end else begin
        perp_q <= ty_q;
        ty_q   <= ty_q + TW'(1024);
        side_q <= 1'b1;
      end
    end
    if (ctl_i.dist_take) begin
      dist_q <= (div_quot[DIV_W-1:16] != '0) ? '1 : div_quot[15:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctl_i.walk_init) begin
      cnt_q <= '0;
    end else if (ctl_i.step) begin
      cnt_q <= cnt_q + SCW'(1);
    end
  end

  // Map memory.
  logic [grc_pkg::CODE_W-1:0] map_mem [DEPTH];
  logic [grc_pkg::CODE_W-1:0] rdata_q;
  logic                       map_we;

  assign map_we = ctl_i.accept && (command_i == grc_pkg::CMD_WRITE) &&
                  (32'(cell_x_i) < MAP_SIZE) && (32'(cell_y_i) < MAP_SIZE);

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[{AW'(cell_y_i), AW'(cell_x_i)}] <= cell_code_i;
    end
    if (ctl_i.step) begin
      rdata_q <= map_mem[{my_n[AW-1:0], mx_n[AW-1:0]}];
    end
  end

  // Wall stripe extent.
  logic [19:0]                lh;
  logic [10:0]                half_h;
  logic signed [20:0]         ds_s;
  logic [20:0]                de_s;
  logic [grc_pkg::ROW_W-1:0]  ds, de;

  always_comb begin
    lh     = (dist_q == '0) ? 20'({h_eff, 1'b0}) : div_quot[19:0];
    half_h = h_eff[11:1];
    ds_s   = $signed({10'd0, half_h}) - $signed({2'd0, lh[19:1]});
    de_s   = {10'd0, half_h} + {2'd0, lh[19:1]};
    if (h_eff == '0) begin
      ds = '0;
      de = '0;
    end else begin
      ds = ds_s[20] ? '0 : ds_s[grc_pkg::ROW_W-1:0];
      de = (de_s >= 21'(h_eff)) ? grc_pkg::ROW_W'(h_eff - 12'd1)
                                : de_s[grc_pkg::ROW_W-1:0];
    end
  end

  // Result register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl_i.push || ctl_i.push_esc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.push) begin
      out_column_o    <= col_q;
      wall_side_o     <= side_q;
      hit_code_o      <= rdata_q;
      wall_distance_o <= dist_q;
      draw_start_o    <= ds;
      draw_end_o      <= de;
      escaped_o       <= 1'b0;
    end else if (ctl_i.push_esc) begin
      out_column_o    <= col_q;
      wall_side_o     <= 1'b0;
      hit_code_o      <= '0;
      wall_distance_o <= '1;
      draw_start_o    <= '0;
      draw_end_o      <= '0;
      escaped_o       <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o.cast_go    = (command_i == grc_pkg::CMD_CAST) && ({1'b0, column_i} < width_q);
    sts_o.div_busy   = div_busy;
    sts_o.escape     = (32'(pos_x_q[15:10]) >= MAP_SIZE) ||
                       (32'(pos_y_q[15:10]) >= MAP_SIZE) ||
                       ((rdx_q == '0) && (rdy_q == '0));
    sts_o.leave      = leave;
    sts_o.hit        = rdata_q != grc_pkg::EMPTY_CODE;
    sts_o.steps_done = cnt_q == SCW'(STEP_MAX);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

endmodule

@@ hdl/grc_ctrl.sv @@
// ----------------------------------------------------------------------------
// grc_ctrl
// Sequencer: camera division, ray setup, walk, distance, line height, result.
// ----------------------------------------------------------------------------
module grc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  grc_pkg::grc_sts_t   sts_i,
  output grc_pkg::grc_ctl_t   ctl_o
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CAM_GO, ST_CAM_WAIT, ST_CAM_FIX, ST_RAY, ST_INIT, ST_STEP, ST_CHECK,
    ST_DIST_GO, ST_DIST_WAIT, ST_LH_GO, ST_LH_WAIT, ST_PUSH, ST_PUSH_ESC
  } state_e;

  state_e state_q, state_d;
  logic   stall_q;

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    case (state_q)
      ST_IDLE: begin
        ctl_o.accept = in_valid_i;
        if (in_valid_i && sts_i.cast_go) begin
          state_d = ST_CAM_GO;
        end
      end
      ST_CAM_GO: begin
        ctl_o.cam_start = 1'b1;
        state_d         = ST_CAM_WAIT;
      end
      ST_CAM_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_CAM_FIX;
        end
      end
      ST_CAM_FIX: begin
        ctl_o.cam_take = 1'b1;
        state_d        = ST_RAY;
      end
      ST_RAY: begin
        ctl_o.ray_load = 1'b1;
        state_d        = ST_INIT;
      end
      ST_INIT: begin
        if (sts_i.escape) begin
          state_d = ST_PUSH_ESC;
        end else begin
          ctl_o.walk_init = 1'b1;
          state_d         = ST_STEP;
        end
      end
      ST_STEP: begin
        ctl_o.step = 1'b1;
        state_d    = sts_i.leave ? ST_PUSH_ESC : ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.hit) begin
          state_d = ST_DIST_GO;
        end else if (sts_i.steps_done) begin
          state_d = ST_PUSH_ESC;
        end else begin
          state_d = ST_STEP;
        end
      end
      ST_DIST_GO: begin
        ctl_o.dist_start = 1'b1;
        state_d          = ST_DIST_WAIT;
      end
      ST_DIST_WAIT: begin
        if (!sts_i.div_busy) begin
          ctl_o.dist_take = 1'b1;
          state_d         = ST_LH_GO;
        end
      end
      ST_LH_GO: begin
        ctl_o.lh_start = 1'b1;
        state_d        = ST_LH_WAIT;
      end
      ST_LH_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          ctl_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_PUSH_ESC: begin
        if (sts_i.out_free) begin
          ctl_o.push_esc = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stall_q <= 1'b0;
    end else begin
      state_q <= state_d;
      stall_q <= state_d != ST_IDLE;
    end
  end

  assign in_stall_o = stall_q;

endmodule

@@ hdl/grc_checker.sv @@
// ----------------------------------------------------------------------------
// grc_checker
// Port-level checks of the grid ray caster column unit, bound to the top.
// ----------------------------------------------------------------------------
module grc_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         cfg_valid_i,
  input logic                         cfg_ready_o,
  input logic [grc_pkg::IDX_W-1:0]    cfg_index_i,
  input logic [grc_pkg::CFG_W-1:0]    cfg_data_i,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         command_i,
  input logic [grc_pkg::COL_W-1:0]    column_i,
  input logic [5:0]                   cell_x_i,
  input logic [5:0]                   cell_y_i,
  input logic [grc_pkg::CODE_W-1:0]   cell_code_i,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [grc_pkg::COL_W-1:0]    out_column_o,
  input logic                         wall_side_o,
  input logic [grc_pkg::CODE_W-1:0]   hit_code_o,
  input logic [grc_pkg::DIST_W-1:0]   wall_distance_o,
  input logic [grc_pkg::ROW_W-1:0]    draw_start_o,
  input logic [grc_pkg::ROW_W-1:0]    draw_end_o,
  input logic                         escaped_o
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its distance and stripe end.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(wall_distance_o) && $stable(draw_end_o))
    else $error("stalled result changed");

  // An escaped ray carries the fixed escape fields.
  a_escape_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && escaped_o |-> wall_distance_o == 16'hFFFF && hit_code_o == '0 &&
      draw_start_o == '0 && draw_end_o == '0 && !wall_side_o)
    else $error("escape result fields wrong");

  // A hit is never on an empty cell and the stripe is ordered.
  a_hit_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !escaped_o |-> hit_code_o != grc_pkg::EMPTY_CODE &&
      draw_start_o <= draw_end_o)
    else $error("hit result inconsistent");

endmodule

bind grid_ray_caster_column_unit grc_checker u_grc_checker (.*);

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// Column ray caster testbench
// Fills the cell map, then sends directed and random cast requests under
// several camera and screen settings and varied handshake pressure. Each
// result is checked against an in-bench DDA predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  localparam int GRID      = 64;
  // Only the corner block of FILL by FILL cells is ever written. Its far
  // row and column stay walls and every camera that walks a ray sits inside
  // it, so no ray reaches a cell outside the block; rays can still leave
  // across the grid edge at row 0 or column 0.
  localparam int FILL      = 16;
  localparam int DRAIN     = 400;      // wait after the last expected result
  localparam int CYCLE_MAX = 4000000;

  // One expected cast result, laid out like the output ports.
  typedef struct packed {
    logic [grc_pkg::COL_W-1:0]  column;
    logic                       side;
    logic [grc_pkg::CODE_W-1:0] code;
    logic [grc_pkg::DIST_W-1:0] distance;
    logic [grc_pkg::ROW_W-1:0]  row_first;
    logic [grc_pkg::ROW_W-1:0]  row_last;
    logic                       escaped;
  } column_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [grc_pkg::IDX_W-1:0] cfg_index_i = '0;
  logic [grc_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic command_i = 1'b0;
  logic [grc_pkg::COL_W-1:0] column_i = '0;
  logic [5:0] cell_x_i = '0;
  logic [5:0] cell_y_i = '0;
  logic [grc_pkg::CODE_W-1:0] cell_code_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [grc_pkg::COL_W-1:0] out_column_o;
  logic wall_side_o;
  logic [grc_pkg::CODE_W-1:0] hit_code_o;
  logic [grc_pkg::DIST_W-1:0] wall_distance_o;
  logic [grc_pkg::ROW_W-1:0] draw_start_o;
  logic [grc_pkg::ROW_W-1:0] draw_end_o;
  logic escaped_o;

  grid_ray_caster_column_unit #(.MAP_SIZE(GRID)) dut (.*);

  always #1 clk_i = ~clk_i;

  // Shadow copies of the camera registers and the cell map.
  logic [15:0]               cam_pos_x, cam_pos_y;
  logic signed [15:0]        cam_dir_x, cam_dir_y, cam_plane_x, cam_plane_y;
  logic [grc_pkg::SCR_W-1:0] scr_width, scr_height;
  logic [7:0]                cell_map [0:GRID*GRID-1];

  column_result_t pending_columns[$];
  int errors = 0;
  int cycles = 0;
  int casts_sent = 0, writes_sent = 0, results_seen = 0, escapes_seen = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  int hold_cycles = 0;

  function automatic longint floor_div(input longint a, input longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q--;
    return q;
  endfunction

  // DDA walk of one column. Returns 0 when the column is dropped.
  function automatic bit trace_column(input logic [grc_pkg::COL_W-1:0] col,
                                      output column_result_t r);
    longint w, h, cam, rdx, rdy, adx, ady, tx, ty, mx, my, stx, sty;
    longint perp, wall_dist, lh, ds, de;
    bit hit, side;
    logic [7:0] code;
    w = scr_width;
    if (longint'(col) >= w) return 1'b0;
    h = (scr_height > grc_pkg::MAX_HEIGHT) ? 2048 : scr_height;
    r = '{column: col, side: 1'b0, code: '0, distance: 16'hFFFF,
          row_first: '0, row_last: '0, escaped: 1'b1};
    cam = floor_div((2 * longint'(col) - w) * 16384, w);
    rdx = longint'(cam_dir_x) + floor_div(longint'(cam_plane_x) * cam, 16384);
    rdy = longint'(cam_dir_y) + floor_div(longint'(cam_plane_y) * cam, 16384);
    mx = cam_pos_x >> 10;
    my = cam_pos_y >> 10;
    if (mx >= GRID || my >= GRID || (rdx == 0 && rdy == 0)) return 1'b1;
    adx = (rdx < 0) ? -rdx : rdx;
    ady = (rdy < 0) ? -rdy : rdy;
    stx = (rdx < 0) ? -1 : 1;
    sty = (rdy < 0) ? -1 : 1;
    tx = (rdx < 0) ? longint'(cam_pos_x[9:0]) : 1024 - longint'(cam_pos_x[9:0]);
    ty = (rdy < 0) ? longint'(cam_pos_y[9:0]) : 1024 - longint'(cam_pos_y[9:0]);
    hit = 1'b0;
    side = 1'b0;
    perp = 0;
    code = '0;
    for (int n = 0; n < 2 * GRID + 4; n++) begin
      // Ties go to the y side.
      if (tx * ady < ty * adx) begin
        perp = tx; tx += 1024; mx += stx; side = 1'b0;
      end else begin
        perp = ty; ty += 1024; my += sty; side = 1'b1;
      end
      if (mx < 0 || mx >= GRID || my < 0 || my >= GRID) break;
      code = cell_map[my * GRID + mx];
      if (code != grc_pkg::EMPTY_CODE) begin
        hit = 1'b1;
        break;
      end
    end
    if (!hit) return 1'b1;
    wall_dist = perp * 4096 / (side ? ady : adx);
    if (wall_dist > 65535) wall_dist = 65535;
    if (h == 0) begin
      ds = 0; de = 0;
    end else begin
      lh = (wall_dist == 0) ? 2 * h : (h * 256) / wall_dist;
      ds = h / 2 - lh / 2;
      if (ds < 0) ds = 0;
      de = h / 2 + lh / 2;
      if (de >= h) de = h - 1;
    end
    r.side = side;
    r.code = code;
    r.distance = wall_dist[15:0];
    r.row_first = ds[10:0];
    r.row_last = de[10:0];
    r.escaped = 1'b0;
    return 1'b1;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Result checker. Outputs are sampled mid-cycle, where they are stable.
  always @(negedge clk_i) begin
    column_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (escaped_o) escapes_seen++;
      if (pending_columns.size() == 0) begin
        report("unexpected result column", out_column_o, -1);
      end else begin
        want = pending_columns.pop_front();
        if (out_column_o !== want.column) report("out_column", out_column_o, want.column);
        if (wall_side_o !== want.side) report("wall_side", wall_side_o, want.side);
        if (hit_code_o !== want.code) report("hit_code", hit_code_o, want.code);
        if (wall_distance_o !== want.distance)
          report("wall_distance", wall_distance_o, want.distance);
        if (draw_start_o !== want.row_first)
          report("draw_start", draw_start_o, want.row_first);
        if (draw_end_o !== want.row_last) report("draw_end", draw_end_o, want.row_last);
        if (escaped_o !== want.escaped) report("escaped", escaped_o, want.escaped);
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_MAX) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Sends one request and predicts it once accepted. Called at a rising edge.
  task automatic send_request(input grc_pkg::grc_op_e op,
                              input logic [grc_pkg::COL_W-1:0] col,
                              input logic [5:0] cx, input logic [5:0] cy,
                              input logic [7:0] code);
    bit taken;
    column_result_t r;
    in_valid_i <= 1'b1;
    command_i <= op;
    column_i <= col;
    cell_x_i <= cx;
    cell_y_i <= cy;
    cell_code_i <= code;
    do begin
      @(negedge clk_i) taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
    if (op == grc_pkg::CMD_WRITE) begin
      cell_map[cy * GRID + cx] = code;
      writes_sent++;
    end else begin
      casts_sent++;
      if (trace_column(col, r)) pending_columns.push_back(r);
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic cast(input int col);
    send_request(grc_pkg::CMD_CAST, col[grc_pkg::COL_W-1:0], 6'($urandom), 6'($urandom),
                 8'($urandom));
  endtask

  task automatic write_cell(input int x, input int y, input int code);
    send_request(grc_pkg::CMD_WRITE, 11'($urandom), x[5:0], y[5:0], code[7:0]);
  endtask

  // Lets every expected result arrive, then waits out the DRAIN margin.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_columns.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Leaves the write offered; set_camera drops it after the last register.
  task automatic write_reg(input grc_pkg::grc_reg_e idx, input logic [15:0] value);
    bit taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    do begin
      @(negedge clk_i) taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
    case (idx)
      grc_pkg::REG_POS_X:   cam_pos_x = value;
      grc_pkg::REG_POS_Y:   cam_pos_y = value;
      grc_pkg::REG_DIR_X:   cam_dir_x = value;
      grc_pkg::REG_DIR_Y:   cam_dir_y = value;
      grc_pkg::REG_PLANE_X: cam_plane_x = value;
      grc_pkg::REG_PLANE_Y: cam_plane_y = value;
      grc_pkg::REG_WIDTH:   scr_width = value[grc_pkg::SCR_W-1:0];
      grc_pkg::REG_HEIGHT:  scr_height = value[grc_pkg::SCR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_camera(input logic [15:0] px, py, dx, dy, plx, ply, w, h);
    wait_idle();
    write_reg(grc_pkg::REG_POS_X, px);
    write_reg(grc_pkg::REG_POS_Y, py);
    write_reg(grc_pkg::REG_DIR_X, dx);
    write_reg(grc_pkg::REG_DIR_Y, dy);
    write_reg(grc_pkg::REG_PLANE_X, plx);
    write_reg(grc_pkg::REG_PLANE_Y, ply);
    write_reg(grc_pkg::REG_WIDTH, w);
    write_reg(grc_pkg::REG_HEIGHT, h);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic int wall_code();
    int c;
    do c = $urandom_range(255); while (c == grc_pkg::EMPTY_CODE);
    return c;
  endfunction

  // Every cell of the block gets written before the first cast: walls on
  // its border, sparse random walls inside.
  task automatic test_fill_map();
    for (int y = 0; y < FILL; y++)
      for (int x = 0; x < FILL; x++) begin
        if (x == 0 || y == 0 || x == FILL - 1 || y == FILL - 1 || $urandom_range(99) < 12)
          write_cell(x, y, wall_code());
        else
          write_cell(x, y, grc_pkg::EMPTY_CODE);
      end
  endtask

  // Casts with the camera left at its reset values.
  task automatic test_reset_camera();
    cast(0); cast(319); cast(320); cast(639);
    cast(640);   // not below the screen width: dropped
    cast(2047);
  endtask

  task automatic test_directed();
    // A ray starting exactly on a cell face next to a wall gives distance
    // zero, and the stripe then fills the whole column.
    write_cell(9, 10, 8'd65);
    set_camera(16'd10240, 16'd10240, 16'hC000, 16'd0, 16'd0, 16'd0, 16'd4, 16'd480);
    cast(0); cast(3);
    // Open the row to the left edge so the same ray leaves the map.
    for (int x = 0; x < 10; x++) write_cell(x, 10, grc_pkg::EMPTY_CODE);
    cast(1);
    write_cell(0, 10, 8'd255);
    write_cell(9, 10, 8'd0);
    // No direction at all escapes at once.
    set_camera(16'd0, 16'd65535, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0);
    cast(0);
    // Extreme direction and plane, widest screen, height clipped to 2048.
    set_camera(16'd15359, 16'd0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'd2048,
               16'd4095);
    cast(0); cast(1023); cast(1024); cast(2047);
    // Zero screen height, narrow one-column screen.
    set_camera(16'd13000, 16'd5000, 16'h4000, 16'h1000, 16'hF000, 16'h2A3D, 16'd1, 16'd0);
    cast(0); cast(1);
    // Zero width drops every cast; height of one row.
    set_camera(16'd40000, 16'd40000, 16'd0, 16'h4000, 16'h2A3D, 16'd0, 16'd0, 16'd1);
    cast(0); cast(5);
  endtask

  function automatic logic [15:0] pick_width();
    case ($urandom_range(4))
      0: return 16'd1;
      1: return 16'd2048;
      2: return 16'($urandom_range(64, 1));
      default: return 16'($urandom_range(2048, 1));
    endcase
  endfunction

  function automatic logic [15:0] pick_height();
    case ($urandom_range(4))
      0: return 16'd0;
      1: return 16'd4095;
      2: return 16'd2048;
      default: return 16'($urandom_range(1200));
    endcase
  endfunction

  // Mostly casts below the width; some map rewrites inside the block, which
  // now and then open holes in row 0 or column 0 so rays can escape.
  task automatic random_phase(input int count);
    int w;
    set_camera(16'($urandom_range((FILL - 1) * 1024 - 1)),
               16'($urandom_range((FILL - 1) * 1024 - 1)),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               pick_width(), pick_height());
    w = scr_width;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0, 1: write_cell($urandom_range(FILL - 2), $urandom_range(FILL - 2),
                         ($urandom_range(2) == 0) ? wall_code() : grc_pkg::EMPTY_CODE);
        2: cast($urandom_range(2047));
        default: cast((w > 0) ? $urandom_range(w - 1) : 0);
      endcase
    end
  endtask

  task automatic test_random(input int sp, input int rp, input int phases);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    for (int p = 0; p < phases; p++) random_phase(100);
  endtask

  // The receiver holds off while requests keep coming, so the output
  // register fills and the input channel stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_camera(16'd7000, 16'd9000, 16'h4000, 16'hE000, 16'h1800, 16'h2A3D,
               16'd64, 16'd480);
    @(negedge clk_i) hold_cycles = 1500;
    @(posedge clk_i);
    for (int i = 0; i < 20; i++) cast($urandom_range(63));
  endtask

  initial begin
    cam_pos_x = grc_pkg::RST_POS_X;
    cam_pos_y = grc_pkg::RST_POS_Y;
    cam_dir_x = grc_pkg::RST_DIR_X;
    cam_dir_y = grc_pkg::RST_DIR_Y;
    cam_plane_x = grc_pkg::RST_PLANE_X;
    cam_plane_y = grc_pkg::RST_PLANE_Y;
    scr_width = grc_pkg::RST_WIDTH;
    scr_height = grc_pkg::RST_HEIGHT;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_map();
    test_reset_camera();
    test_directed();
    test_random(24, 52, 4);
    test_random(52, 24, 4);
    test_random(0, 0, 4);
    test_backpressure();

    wait_idle();
    $display("Covered %0d casts and %0d cell writes; %0d results checked, %0d escaped.",
             casts_sent, writes_sent, results_seen, escapes_seen);
    $display("Camera extremes, zero width and height, and a long output hold-off were run.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/grc_pkg.sv
hdl/grc_div.sv
hdl/grc_datapath.sv
hdl/grc_ctrl.sv
hdl/grid_ray_caster_column_unit.sv
hdl/grc_checker.sv
bench/testbench.sv
